// ----- hw/rtl/symmetry_op_parse_and_apply_unit_macros.svh -----
// Assertion macros shared by the symmetry operation unit.
`ifndef SYMMETRY_OP_PARSE_AND_APPLY_UNIT_MACROS_SVH
`define SYMMETRY_OP_PARSE_AND_APPLY_UNIT_MACROS_SVH

// Checks a property on every rising edge of clk_i outside reset.
`define SOPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds.
`define SOPA_ASSERT_NEVER(lbl, cond, msg) \
  `SOPA_ASSERT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/sopa_pkg.sv -----
// Types, codes and constants of the symmetry operation unit.
`timescale 1ns / 1ps
`default_nettype none

package sopa_pkg;

  localparam int FracBits   = 24;
  localparam int CoordBits  = 32;
  localparam int BiasBits   = 32;
  localparam int QueueDepth = 2;
  localparam int NumAxes    = 3;
  localparam int NumWeights = 9;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChY     = 8'h79;
  localparam logic [7:0] ChZ     = 8'h7A;

  localparam logic [1:0] WgtZero  = 2'd0;
  localparam logic [1:0] WgtPlus  = 2'd1;
  localparam logic [1:0] WgtMinus = 2'd3;

  localparam logic [1:0] AxisIgnore = 2'd3;

  localparam logic KindParse = 1'b0;
  localparam logic KindXform = 1'b1;

  typedef enum logic [1:0] {
    SignNone  = 2'd0,
    SignPlus  = 2'd1,
    SignMinus = 2'd2
  } sign_e;

  typedef enum logic [2:0] {
    ClsPlus,
    ClsMinus,
    ClsVar,
    ClsSlash,
    ClsComma,
    ClsDigit,
    ClsOther,
    ClsXform
  } char_class_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkDiv,
    BkSum,
    BkWrap,
    BkDone
  } back_state_e;

  typedef struct packed {
    logic                        action;
    logic [7:0]                  char_code;
    logic                        last_char;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic                        result_kind;
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] out_z;
    logic [1:0]                  axis_now;
  } out_item_t;

  typedef struct packed {
    char_class_e                 cls;
    logic                        last;
    logic [3:0]                  arg;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
  } q_entry_t;

  typedef struct packed {
    logic                start;
    logic [BiasBits-1:0] value;
    logic [3:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [BiasBits-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sopa_front.sv -----
// Front end: accepts items and classifies each character.
`timescale 1ns / 1ps
`default_nettype none

module sopa_front (
  input  wire  logic                 in_valid_i,
  output logic                       in_stall_o,
  input  wire  sopa_pkg::in_item_t   in_data_i,
  input  wire  logic                 full_i,
  output logic                       push_o,
  output sopa_pkg::q_entry_t         entry_o
);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.cls     = sopa_pkg::ClsOther;
    entry_o.last    = in_data_i.last_char;
    entry_o.arg     = '0;
    entry_o.coord_x = in_data_i.coord_x;
    entry_o.coord_y = in_data_i.coord_y;
    entry_o.coord_z = in_data_i.coord_z;
    if (in_data_i.action == sopa_pkg::KindXform) begin
      entry_o.cls = sopa_pkg::ClsXform;
    end else begin
      unique case (in_data_i.char_code) inside
        sopa_pkg::ChPlus: begin
          entry_o.cls = sopa_pkg::ClsPlus;
        end
        sopa_pkg::ChMinus: begin
          entry_o.cls = sopa_pkg::ClsMinus;
        end
        sopa_pkg::ChX, sopa_pkg::ChY, sopa_pkg::ChZ: begin
          entry_o.cls = sopa_pkg::ClsVar;
          entry_o.arg = 4'(in_data_i.char_code - sopa_pkg::ChX);
        end
        sopa_pkg::ChSlash: begin
          entry_o.cls = sopa_pkg::ClsSlash;
        end
        sopa_pkg::ChComma: begin
          entry_o.cls = sopa_pkg::ClsComma;
        end
        [sopa_pkg::ChOne:sopa_pkg::ChNine]: begin
          entry_o.cls = sopa_pkg::ClsDigit;
          entry_o.arg = 4'(in_data_i.char_code - sopa_pkg::ChZero);
        end
        default: begin
          entry_o.cls = sopa_pkg::ClsOther;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sopa_queue.sv -----
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "symmetry_op_parse_and_apply_unit_macros.svh"

module sopa_queue #(
  parameter int DEPTH = sopa_pkg::QueueDepth
) (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               push_i,
  input  wire  sopa_pkg::q_entry_t entry_i,
  output logic                     full_o,
  input  wire  logic               pop_i,
  output sopa_pkg::q_entry_t       entry_o,
  output logic                     empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  sopa_pkg::q_entry_t mem_q [DEPTH];
  logic [PtrW-1:0]    wr_q, wr_d;
  logic [PtrW-1:0]    rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  `SOPA_ASSERT_NEVER(a_no_overflow, push_i && full_o, "Queue written while full.")
  `SOPA_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "Queue read while empty.")

endmodule

`default_nettype wire

// ----- hw/rtl/sopa_div.sv -----
// Bit-serial signed divider of the bias by one decimal digit.
`timescale 1ns / 1ps
`default_nettype none

module sopa_div (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  sopa_pkg::div_req_t req_i,
  output sopa_pkg::div_rsp_t       rsp_o
);

  localparam int W    = sopa_pkg::BiasBits;
  localparam int CntW = $clog2(W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic            neg_q;
  logic [W-1:0]    sh_q;
  logic [3:0]      rem_q;
  logic [3:0]      d_q;
  logic [W-1:0]    quo_q;

  logic [4:0]      trial;
  logic            ge;
  logic [3:0]      rem_nx;
  logic [W-1:0]    sh_nx;
  logic [W-1:0]    quo_nx;
  logic [W-1:0]    mag;

  assign trial  = {rem_q, sh_q[W-1]};
  assign ge     = (trial >= {1'b0, d_q});
  assign rem_nx = ge ? 4'(trial - {1'b0, d_q}) : trial[3:0];
  assign sh_nx  = {sh_q[W-2:0], ge};
  assign quo_nx = neg_q ? (W'(0) - sh_nx) : sh_nx;
  assign mag    = req_i.value[W-1] ? (W'(0) - req_i.value) : req_i.value;

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.value[W-1];
      sh_q  <= mag;
      rem_q <= '0;
      d_q   <= req_i.divisor;
    end else if (busy_q) begin
      sh_q  <= sh_nx;
      rem_q <= rem_nx;
      if (cnt_q == '0) begin
        quo_q <= quo_nx;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sopa_back.sv -----
// Back end: parse state, transform datapath and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "symmetry_op_parse_and_apply_unit_macros.svh"

module sopa_back #(
  parameter int FRAC_BITS = sopa_pkg::FracBits
) (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               q_empty_i,
  input  wire  sopa_pkg::q_entry_t q_entry_i,
  output logic                     q_pop_o,
  output sopa_pkg::div_req_t       div_req_o,
  input  wire  sopa_pkg::div_rsp_t div_rsp_i,
  output logic                     out_valid_o,
  input  wire  logic               out_stall_i,
  output sopa_pkg::out_item_t      out_data_o
);

  localparam int CW   = sopa_pkg::CoordBits;
  localparam int BW   = sopa_pkg::BiasBits;
  localparam int NA   = sopa_pkg::NumAxes;
  localparam int NW   = sopa_pkg::NumWeights;
  localparam int AccW = ((CW > BW) ? CW : BW) + 3;
  localparam logic signed [AccW-1:0] OneFx = AccW'(1) << FRAC_BITS;

  sopa_pkg::back_state_e state_q, state_d;
  logic [1:0]            w_q [NW];
  logic [1:0]            w_d [NW];
  logic signed [BW-1:0]  bias_q [NA];
  logic signed [BW-1:0]  bias_d [NA];
  sopa_pkg::sign_e       sign_q, sign_d;
  logic                  den_q, den_d;
  logic [BW-1:0]         run_q, run_d;
  logic [1:0]            axis_q, axis_d;
  logic                  fresh_q, fresh_d;
  logic                  last_q, last_d;
  logic                  out_valid_q;
  sopa_pkg::out_item_t   res_q, res_d;
  sopa_pkg::out_item_t   out_q;
  logic signed [CW-1:0]  cx_q, cy_q, cz_q;
  logic signed [AccW-1:0] acc_q [NA];
  logic signed [AccW-1:0] acc_sum [NA];
  logic signed [AccW-1:0] wrap_val [NA];

  logic [1:0]            axis_eff;
  logic [3:0]            widx;
  logic [BW-1:0]         digit_val;
  logic                  load_out;

  function automatic logic signed [AccW-1:0] term(input logic [1:0] code,
                                                  input logic signed [CW-1:0] c);
    case (code)
      sopa_pkg::WgtPlus:  term = AccW'(c);
      sopa_pkg::WgtMinus: term = -AccW'(c);
      default:            term = '0;
    endcase
  endfunction

  assign axis_eff  = fresh_q ? 2'd0 : axis_q;
  assign widx      = 4'(axis_eff) * 4'(NA) + 4'(q_entry_i.arg[1:0]);
  assign digit_val = BW'(q_entry_i.arg) << FRAC_BITS;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      acc_sum[i] = AccW'(bias_q[i]) + term(w_q[NA*i], cx_q)
                 + term(w_q[NA*i + 1], cy_q) + term(w_q[NA*i + 2], cz_q);
      if (acc_q[i] < 0) begin
        wrap_val[i] = acc_q[i] + OneFx;
      end else if (acc_q[i] >= OneFx) begin
        wrap_val[i] = acc_q[i] - OneFx;
      end else begin
        wrap_val[i] = acc_q[i];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    bias_d    = bias_q;
    sign_d    = sign_q;
    den_d     = den_q;
    run_d     = run_q;
    axis_d    = axis_q;
    fresh_d   = fresh_q;
    last_d    = last_q;
    res_d     = res_q;
    q_pop_o   = 1'b0;
    div_req_o = '0;
    load_out  = 1'b0;
    unique case (state_q)
      sopa_pkg::BkIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.cls == sopa_pkg::ClsXform) begin
            state_d = sopa_pkg::BkSum;
          end else if (q_entry_i.cls == sopa_pkg::ClsDigit && !fresh_q && den_q) begin
            div_req_o.start   = 1'b1;
            div_req_o.value   = run_q;
            div_req_o.divisor = q_entry_i.arg;
            last_d            = q_entry_i.last;
            state_d           = sopa_pkg::BkDiv;
          end else begin
            if (fresh_q) begin
              for (int k = 0; k < NW; k++) w_d[k] = sopa_pkg::WgtZero;
              for (int k = 0; k < NA; k++) bias_d[k] = '0;
              sign_d  = sopa_pkg::SignNone;
              den_d   = 1'b0;
              run_d   = '0;
              axis_d  = 2'd0;
              fresh_d = 1'b0;
            end
            unique case (q_entry_i.cls)
              sopa_pkg::ClsPlus: begin
                sign_d = sopa_pkg::SignPlus;
              end
              sopa_pkg::ClsMinus: begin
                sign_d = sopa_pkg::SignMinus;
              end
              sopa_pkg::ClsVar: begin
                if (sign_d == sopa_pkg::SignNone) sign_d = sopa_pkg::SignPlus;
                for (int k = 0; k < NW; k++) begin
                  if (axis_d != sopa_pkg::AxisIgnore && widx == 4'(k)) begin
                    w_d[k] = (sign_d == sopa_pkg::SignMinus) ? sopa_pkg::WgtMinus
                                                             : sopa_pkg::WgtPlus;
                  end
                end
              end
              sopa_pkg::ClsSlash: begin
                den_d = 1'b1;
              end
              sopa_pkg::ClsComma: begin
                for (int k = 0; k < NA; k++) begin
                  if (axis_d == 2'(k)) bias_d[k] = run_d;
                end
                sign_d = sopa_pkg::SignNone;
                den_d  = 1'b0;
                run_d  = '0;
                if (axis_d != sopa_pkg::AxisIgnore) axis_d = axis_d + 1'b1;
              end
              sopa_pkg::ClsDigit: begin
                run_d = (sign_d == sopa_pkg::SignMinus) ? -digit_val : digit_val;
              end
              default: begin
              end
            endcase
            if (q_entry_i.last) begin
              for (int k = 0; k < NA; k++) begin
                if (axis_d == 2'(k)) bias_d[k] = run_d;
              end
              sign_d  = sopa_pkg::SignNone;
              den_d   = 1'b0;
              run_d   = '0;
              axis_d  = 2'd0;
              fresh_d = 1'b1;
            end
            res_d.result_kind = sopa_pkg::KindParse;
            res_d.out_x       = '0;
            res_d.out_y       = '0;
            res_d.out_z       = '0;
            res_d.axis_now    = axis_d;
            state_d           = sopa_pkg::BkDone;
          end
        end
      end
      sopa_pkg::BkDiv: begin
        if (div_rsp_i.done) begin
          run_d = div_rsp_i.quotient;
          if (last_q) begin
            for (int k = 0; k < NA; k++) begin
              if (axis_d == 2'(k)) bias_d[k] = run_d;
            end
            sign_d  = sopa_pkg::SignNone;
            den_d   = 1'b0;
            run_d   = '0;
            axis_d  = 2'd0;
            fresh_d = 1'b1;
          end
          res_d.result_kind = sopa_pkg::KindParse;
          res_d.out_x       = '0;
          res_d.out_y       = '0;
          res_d.out_z       = '0;
          res_d.axis_now    = axis_d;
          state_d           = sopa_pkg::BkDone;
        end
      end
      sopa_pkg::BkSum: begin
        state_d = sopa_pkg::BkWrap;
      end
      sopa_pkg::BkWrap: begin
        res_d.result_kind = sopa_pkg::KindXform;
        res_d.out_x       = wrap_val[0][CW-1:0];
        res_d.out_y       = wrap_val[1][CW-1:0];
        res_d.out_z       = wrap_val[2][CW-1:0];
        res_d.axis_now    = axis_q;
        state_d           = sopa_pkg::BkDone;
      end
      sopa_pkg::BkDone: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = sopa_pkg::BkIdle;
        end
      end
      default: begin
        state_d = sopa_pkg::BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sopa_pkg::BkIdle;
      for (int k = 0; k < NW; k++) w_q[k] <= sopa_pkg::WgtZero;
      for (int k = 0; k < NA; k++) bias_q[k] <= '0;
      sign_q      <= sopa_pkg::SignNone;
      den_q       <= 1'b0;
      run_q       <= '0;
      axis_q      <= 2'd0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      bias_q  <= bias_d;
      sign_q  <= sign_d;
      den_q   <= den_d;
      run_q   <= run_d;
      axis_q  <= axis_d;
      fresh_q <= fresh_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    res_q  <= res_d;
    acc_q  <= acc_sum;
    if (state_q == sopa_pkg::BkIdle && !q_empty_i) begin
      cx_q <= q_entry_i.coord_x;
      cy_q <= q_entry_i.coord_y;
      cz_q <= q_entry_i.coord_z;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SOPA_ASSERT(a_fresh_clean,
    fresh_q |-> (axis_q == 2'd0) && !den_q && (run_q == '0) && (sign_q == sopa_pkg::SignNone),
    "A new string must start from a cleared part.")
  `SOPA_ASSERT(a_div_in_den, (state_q == sopa_pkg::BkDiv) |-> den_q && !fresh_q,
    "Division runs only inside a denominator.")

endmodule

`default_nettype wire

// ----- hw/rtl/symmetry_op_parse_and_apply_unit.sv -----
// Top level of the symmetry operation parse and apply unit.
// Parse items pass the queue, result and output registers, one at a time.
// A digit after '/' goes through the 32-step bit-serial divider.
// A transform item passes coordinate, accumulate, wrap and output registers.
// Reset clears all weights and biases and the parse state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module symmetry_op_parse_and_apply_unit #(
  parameter int FRAC_BITS   = sopa_pkg::FracBits,
  parameter int QUEUE_DEPTH = sopa_pkg::QueueDepth
) (
  input  wire  logic                clk_i,
  input  wire  logic                rst_ni,
  input  wire  logic                in_valid_i,
  output logic                      in_stall_o,
  input  wire  sopa_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire  logic                out_stall_i,
  output sopa_pkg::out_item_t       out_data_o
);

  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  sopa_pkg::q_entry_t entry_in;
  sopa_pkg::q_entry_t entry_out;
  sopa_pkg::div_req_t div_req;
  sopa_pkg::div_rsp_t div_rsp;

  sopa_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry_in)
  );

  sopa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (entry_out),
    .empty_o (empty)
  );

  sopa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sopa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_entry_i   (entry_out),
    .q_pop_o     (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
